[rtl/assert_macros.svh]
// Assertion macros shared by the cipher unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TRRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/trrc_pkg.sv]
// Types, constants and helper functions of the three rotor reflector cipher unit.
`default_nettype none

package trrc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int REFLECT_SHIFT = 13;
  localparam int ROTOR_COUNT   = 3;
  localparam int SYM_W         = 5;
  localparam int SUM_W         = SYM_W + 2;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_CIPHER = 2'd0;
  localparam logic [1:0] MODE_WIRE   = 2'd1;
  localparam logic [1:0] MODE_REWIND = 2'd2;

  localparam logic [1:0] ROTOR_ONE   = 2'd0;
  localparam logic [1:0] ROTOR_TWO   = 2'd1;
  localparam logic [1:0] ROTOR_THREE = 2'd2;

  localparam logic [1:0] CFG_START_ONE   = 2'd0;
  localparam logic [1:0] CFG_START_TWO   = 2'd1;
  localparam logic [1:0] CFG_START_THREE = 2'd2;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sym_t one;
    sym_t two;
    sym_t three;
  } offsets_t;

  typedef struct packed {
    sym_t     letter;
    offsets_t offs;
  } letter_item_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    sym_t       idx;
    sym_t       val;
  } wire_write_t;

  typedef struct packed {
    logic queue_empty;
    logic pipe_busy;
  } back_status_t;

  // Reduces a sum below three alphabet lengths into the alphabet.
  function automatic sym_t mod_alpha(input sum_t s);
    sum_t r;
    if (s >= sum_t'(2 * ALPHABET_SIZE)) begin
      r = s - sum_t'(2 * ALPHABET_SIZE);
    end else if (s >= sum_t'(ALPHABET_SIZE)) begin
      r = s - sum_t'(ALPHABET_SIZE);
    end else begin
      r = s;
    end
    return r[SYM_W-1:0];
  endfunction

  function automatic sum_t widen(input sym_t v);
    return {2'b00, v};
  endfunction

endpackage

`default_nettype wire

[rtl/trrc_front.sv]
// Front end: accepts input transactions, classifies them, keeps rotor offsets.
`default_nettype none
`include "assert_macros.svh"

module trrc_front import trrc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // letter[4:0], rotor_select[6:5], wiring_index[11:7], wiring_value[16:12], zeros
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [SYM_W-1:0]      cfg_data,
  input  wire back_status_t          status_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output letter_item_t               q_entry_o,
  output wire_write_t                wr_o
);

  logic       accept;
  logic       pipe_idle;
  logic       offs_ok;
  logic [1:0] mode;
  sym_t       letter;
  logic [1:0] rotor_sel;
  sym_t       wire_idx;
  sym_t       wire_val;
  offsets_t   off_r;
  offsets_t   off_nxt;
  offsets_t   start_r;
  offsets_t   start_nxt;

  assign mode      = in_tuser;
  assign letter    = in_tdata[4:0];
  assign rotor_sel = in_tdata[6:5];
  assign wire_idx  = in_tdata[11:7];
  assign wire_val  = in_tdata[16:12];

  assign pipe_idle = status_i.queue_empty && !status_i.pipe_busy;

  always_comb begin
    unique case (mode)
      MODE_CIPHER: in_tready = !q_full_i;
      MODE_WIRE:   in_tready = pipe_idle;
      default:     in_tready = 1'b1;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  assign q_push_o         = accept && (mode == MODE_CIPHER);
  assign q_entry_o.letter = letter;
  assign q_entry_o.offs   = off_r;

  assign wr_o.en  = accept && (mode == MODE_WIRE) && (rotor_sel < 2'(ROTOR_COUNT))
                    && (wire_idx < sym_t'(ALPHABET_SIZE));
  assign wr_o.sel = rotor_sel;
  assign wr_o.idx = wire_idx;
  assign wr_o.val = wire_val;

  always_comb begin
    off_nxt = off_r;
    if (accept && (mode == MODE_CIPHER)) begin
      off_nxt.one   = mod_alpha(widen(off_r.one) + sum_t'(2));
      off_nxt.two   = mod_alpha(widen(off_r.two) + sum_t'(2));
      off_nxt.three = mod_alpha(widen(off_r.three) + sum_t'(2));
    end else if (accept && (mode == MODE_REWIND)) begin
      off_nxt.one   = mod_alpha(widen(start_r.one));
      off_nxt.two   = mod_alpha(widen(start_r.two));
      off_nxt.three = mod_alpha(widen(start_r.three));
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    start_nxt = start_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_ONE:   start_nxt.one   = cfg_data;
        CFG_START_TWO:   start_nxt.two   = cfg_data;
        CFG_START_THREE: start_nxt.three = cfg_data;
        default:         start_nxt       = start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      start_r <= '0;
    end else begin
      off_r   <= off_nxt;
      start_r <= start_nxt;
    end
  end

  assign offs_ok = (off_r.one < sym_t'(ALPHABET_SIZE)) && (off_r.two < sym_t'(ALPHABET_SIZE))
                   && (off_r.three < sym_t'(ALPHABET_SIZE));

  `TRRC_ASSERT(a_wire_write_idle, wr_o.en |-> pipe_idle, "wiring written with letters in flight")
  `TRRC_ASSERT(a_offsets_in_range, offs_ok, "rotor offset out of range")

endmodule

`default_nettype wire

[rtl/trrc_queue.sv]
// Short queue of letter transactions between the front end and the rotor pipeline.
`default_nettype none
`include "assert_macros.svh"

module trrc_queue import trrc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire letter_item_t entry_i,
  input  wire logic         pop_i,
  output letter_item_t      head_o,
  output logic              head_valid_o,
  output logic              full_o,
  output logic              empty_o
);

  letter_item_t        q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_r;
  logic [QPTR_W-1:0]   wp_nxt;
  logic [QPTR_W-1:0]   rp_r;
  logic [QPTR_W-1:0]   rp_nxt;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign empty_o      = (count_r == '0);
  assign full_o       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = !empty_o;
  assign head_o       = q_mem[rp_r];

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push_i) begin
      wp_nxt = (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (pop_i) begin
      rp_nxt = (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_mem[wp_r] <= entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  `TRRC_ASSERT(a_no_overflow, !(push_i && full_o), "push into full queue")
  `TRRC_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from empty queue")

endmodule

`default_nettype wire

[rtl/trrc_back.sv]
// Back end: six stage rotor pipeline with the three wiring memories and the result register.
`default_nettype none

module trrc_back import trrc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire letter_item_t           head_i,
  input  wire logic                   head_valid_i,
  output logic                        pop_o,
  output logic                        busy_o,
  input  wire wire_write_t            wr_i,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // cipher_letter[4:0], zeros
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  sym_t       rot1_mem [ALPHABET_SIZE];
  sym_t       rot2_mem [ALPHABET_SIZE];
  sym_t       rot3_mem [ALPHABET_SIZE];

  logic [6:1] v_r;
  logic       en;
  offsets_t   o1_r, o2_r, o3_r, o4_r, o5_r;
  sym_t       d1_r, d2_r, d3_r, d4_r, d5_r, d6_r;
  sym_t       addr1, addr2, addr3, addr4, addr5, addr6;

  assign en     = !v_r[6] || out_tready;
  assign pop_o  = en && head_valid_i;
  assign busy_o = |v_r[5:1];

  assign addr1 = mod_alpha(widen(head_i.letter) + widen(head_i.offs.one));
  assign addr2 = mod_alpha(widen(d1_r) + widen(o1_r.two));
  assign addr3 = mod_alpha(widen(d2_r) + widen(o2_r.three));
  assign addr4 = mod_alpha(widen(d3_r) + sum_t'(REFLECT_SHIFT) + widen(o3_r.three)
                           + sum_t'(1));
  assign addr5 = mod_alpha(widen(d4_r) + widen(o4_r.two) + sum_t'(1));
  assign addr6 = mod_alpha(widen(d5_r) + widen(o5_r.one) + sum_t'(1));

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.sel == ROTOR_ONE)) begin
      rot1_mem[wr_i.idx] <= wr_i.val;
    end
    if (en) begin
      d1_r <= rot1_mem[addr1];
      d6_r <= rot1_mem[addr6];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.sel == ROTOR_TWO)) begin
      rot2_mem[wr_i.idx] <= wr_i.val;
    end
    if (en) begin
      d2_r <= rot2_mem[addr2];
      d5_r <= rot2_mem[addr5];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.sel == ROTOR_THREE)) begin
      rot3_mem[wr_i.idx] <= wr_i.val;
    end
    if (en) begin
      d3_r <= rot3_mem[addr3];
      d4_r <= rot3_mem[addr4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1_r <= head_i.offs;
      o2_r <= o1_r;
      o3_r <= o2_r;
      o4_r <= o3_r;
      o5_r <= o4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], head_valid_i};
    end
  end

  assign out_tvalid = v_r[6];
  assign out_tdata  = {(OUT_TDATA_W - SYM_W)'(0), d6_r};

endmodule

`default_nettype wire

[rtl/three_rotor_reflector_cipher_unit.sv]
// Letters pass the queue and rotor pipeline, one letter per cycle while out_tready is high.
// Rewind and unused-mode transactions are always accepted and give no result.
// Wiring writes wait out letters queued or before the last stage, longer while out_tready is low.
// The six chained wiring lookups, two per rotor memory port pair, set the pipeline depth.
// Synchronous active-low reset clears offsets, start registers, queue and pipeline valids;
// the wiring memories keep their contents and need no clearing.
`default_nettype none

module three_rotor_reflector_cipher_unit import trrc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // letter[4:0], rotor_select[6:5], wiring_index[11:7], wiring_value[16:12], zeros
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // cipher_letter[4:0], zeros
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [SYM_W-1:0]       cfg_data
);

  back_status_t status;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  logic         head_valid;
  logic         pipe_busy;
  letter_item_t q_entry;
  letter_item_t head;
  wire_write_t  wr;

  assign status.queue_empty = q_empty;
  assign status.pipe_busy   = pipe_busy;

  trrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status_i  (status),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry),
    .wr_o      (wr)
  );

  trrc_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .pop_i        (q_pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  trrc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (q_pop),
    .busy_o       (pipe_busy),
    .wr_i         (wr),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of the three rotor reflector cipher unit with a predicting scoreboard.
`default_nettype none

module tb_top;
  import trrc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] ROTOR_NONE  = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 300;

  class cipher_scoreboard;
    sym_t        wiring [ROTOR_COUNT][ALPHABET_SIZE];
    int unsigned offsets [ROTOR_COUNT];
    sym_t        start_offsets [ROTOR_COUNT];
    sym_t        expected_letters [$];
    int unsigned error_count;

    function new();
      foreach (offsets[r]) begin
        offsets[r]       = 0;
        start_offsets[r] = '0;
      end
      error_count = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    function void note_config(input logic [1:0] idx, input sym_t data);
      case (idx)
        CFG_START_ONE:   start_offsets[0] = data;
        CFG_START_TWO:   start_offsets[1] = data;
        CFG_START_THREE: start_offsets[2] = data;
        default: ;
      endcase
    endfunction

    function int unsigned rotor_lookup(input int r, input int unsigned x);
      int unsigned pos;
      int unsigned v;
      pos = (x + offsets[r]) % ALPHABET_SIZE;
      v = wiring[r][pos];
      offsets[r] = (offsets[r] + 1) % ALPHABET_SIZE;
      return v;
    endfunction

    function sym_t encipher(input sym_t letter);
      int unsigned x;
      x = letter;
      x = rotor_lookup(0, x);
      x = rotor_lookup(1, x);
      x = rotor_lookup(2, x);
      x = (x + REFLECT_SHIFT) % ALPHABET_SIZE;
      x = rotor_lookup(2, x);
      x = rotor_lookup(1, x);
      x = rotor_lookup(0, x);
      return sym_t'(x);
    endfunction

    function void note_item(input logic [1:0] mode, input logic [IN_TDATA_W-1:0] data);
      sym_t       letter;
      logic [1:0] sel;
      sym_t       idx;
      sym_t       val;
      letter = data[4:0];
      sel    = data[6:5];
      idx    = data[11:7];
      val    = data[16:12];
      case (mode)
        MODE_CIPHER: expected_letters.push_back(encipher(letter));
        MODE_WIRE: begin
          if (sel != ROTOR_NONE && idx < ALPHABET_SIZE) wiring[sel][idx] = val;
        end
        MODE_REWIND: begin
          foreach (offsets[r]) offsets[r] = start_offsets[r] % ALPHABET_SIZE;
        end
        default: ;
      endcase
    endfunction

    task check_letter(input sym_t got);
      sym_t want;
      if (expected_letters.size() == 0) begin
        report_mismatch($sformatf("cipher letter %0d arrived with none expected", got));
      end else begin
        want = expected_letters.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("cipher letter %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [SYM_W-1:0]       cfg_data;

  cipher_scoreboard sb;
  bit idle_on;
  int out_stall_left = 0;
  int quiet_cycles = 0;

  three_rotor_reflector_cipher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [IN_TDATA_W-1:0] pack_item(input sym_t letter,
                                                      input logic [1:0] sel,
                                                      input sym_t idx, input sym_t val);
    return {7'b0, val, idx, sel, letter};
  endfunction

  function automatic sym_t rand_symbol();
    return ($urandom_range(0, 7) == 0) ? sym_t'($urandom_range(26, 31))
                                       : sym_t'($urandom_range(0, 25));
  endfunction

  task automatic push_item(input logic [1:0] mode, input logic [IN_TDATA_W-1:0] data);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(mode, data);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input sym_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
  endtask

  // Waits for all letters to come back and for trailing wiring writes to retire.
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.expected_letters.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_random();
    int         pick;
    logic [1:0] mode;
    logic [1:0] sel;
    pick = $urandom_range(0, 99);
    if (pick < 70) mode = MODE_CIPHER;
    else if (pick < 86) mode = MODE_WIRE;
    else if (pick < 93) mode = MODE_REWIND;
    else mode = MODE_UNUSED;
    sel = ($urandom_range(0, 11) == 0) ? ROTOR_NONE : 2'($urandom_range(0, 2));
    push_item(mode, pack_item(rand_symbol(), sel, rand_symbol(), rand_symbol()));
  endtask

  task automatic load_wiring();
    for (int r = 0; r < ROTOR_COUNT; r++) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        push_item(MODE_WIRE, pack_item(rand_symbol(), 2'(r), sym_t'(i), rand_symbol()));
      end
    end
  endtask

  task automatic run_directed();
    push_item(MODE_REWIND, pack_item(5'd0, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd0, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd25, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd26, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd31, ROTOR_NONE, 5'd31, 5'd31));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_NONE, 5'd3, 5'd7));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_ONE, 5'd26, 5'd5));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_THREE, 5'd31, 5'd31));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_THREE, 5'd25, 5'd31));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_ONE, 5'd0, 5'd31));
    push_item(MODE_WIRE, pack_item(5'd0, ROTOR_TWO, 5'd12, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd1, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_CIPHER, pack_item(5'd30, ROTOR_ONE, 5'd0, 5'd0));
    push_item(MODE_UNUSED, pack_item(5'd31, ROTOR_NONE, 5'd31, 5'd31));
    push_item(MODE_REWIND, pack_item(5'd31, ROTOR_NONE, 5'd31, 5'd31));
    for (int i = 0; i < 4; i++) begin
      push_item(MODE_CIPHER, pack_item(sym_t'(i * 8), ROTOR_ONE, 5'd0, 5'd0));
    end
  endtask

  always @(negedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 9) == 0) begin
      out_stall_left = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_letter(out_tdata[SYM_W-1:0]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sym_t s_one;
    sym_t s_two;
    sym_t s_three;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_CIPHER;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_ONE;
    cfg_data  = '0;
    idle_on   = 1'b0;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      if (p > 0) settle();
      case (p)
        0: begin
          s_one = 5'd0; s_two = 5'd0; s_three = 5'd0;
        end
        1: begin
          s_one = 5'd25; s_two = 5'd25; s_three = 5'd25;
        end
        2: begin
          s_one = 5'd31; s_two = 5'd26; s_three = 5'd30;
        end
        default: begin
          s_one = sym_t'($urandom_range(0, 31));
          s_two = sym_t'($urandom_range(0, 31));
          s_three = sym_t'($urandom_range(0, 31));
        end
      endcase
      write_reg(CFG_START_ONE, s_one);
      write_reg(CFG_START_TWO, s_two);
      write_reg(CFG_START_THREE, s_three);
      if (p == 2 || p == 4) write_reg(CFG_UNUSED, sym_t'($urandom_range(0, 31)));
      cfg_valid <= 1'b0;
      if (p == 0) begin
        load_wiring();
        run_directed();
      end
      push_item(MODE_REWIND, pack_item(rand_symbol(), ROTOR_ONE, rand_symbol(), rand_symbol()));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          do @(negedge clk); while (sb.expected_letters.size() != 0);
        end
        push_random();
      end
    end
    settle();
    if (sb.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
